@@ sv/lmws_pkg.sv @@
`default_nettype none
package lmws_pkg;

    // Fixed field widths of the request and result channels.
    localparam int KIND_W   = 2;
    localparam int ROW_W    = 4;
    localparam int COL_W    = 5;
    localparam int PIX_W    = 24;
    localparam int DIR_W    = 2;
    localparam int STEP_W   = 16;
    localparam int ROWS_W   = 5;
    localparam int COLS_W   = 6;
    localparam int LIMIT_W  = 16;
    localparam int ELAPSE_W = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FILL  = 2'd3;

    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd2;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd2;

    localparam logic [ROWS_W-1:0]   ROWS_RESET  = 5'd16;
    localparam logic [COLS_W-1:0]   COLS_RESET  = 6'd32;
    localparam logic [ELAPSE_W-1:0] ELAPSE_MAX  = 17'h1FFFF;

    // Source of a cell's next value.
    typedef enum logic [2:0] {
        SEL_HOLD,
        SEL_LOAD,
        SEL_NEXT_COL,
        SEL_PREV_COL,
        SEL_NEXT_ROW,
        SEL_PREV_ROW,
        SEL_WRAP
    } cell_sel_t;

endpackage
`default_nettype wire

@@ sv/lmws_cell.sv @@
`default_nettype none
module lmws_cell
    import lmws_pkg::*;
#(
    parameter int PW = 24
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cell_sel_t     sel,
    input  wire logic [PW-1:0] load_data,
    input  wire logic [PW-1:0] next_col,
    input  wire logic [PW-1:0] prev_col,
    input  wire logic [PW-1:0] next_row,
    input  wire logic [PW-1:0] prev_row,
    input  wire logic [PW-1:0] wrap_data,
    output logic      [PW-1:0] value
);

    logic [PW-1:0] value_reg;
    logic [PW-1:0] value_next;

    always_comb
    begin
        unique case (sel)
            SEL_HOLD:     value_next = value_reg;
            SEL_LOAD:     value_next = load_data;
            SEL_NEXT_COL: value_next = next_col;
            SEL_PREV_COL: value_next = prev_col;
            SEL_NEXT_ROW: value_next = next_row;
            SEL_PREV_ROW: value_next = prev_row;
            SEL_WRAP:     value_next = wrap_data;
            default:      value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            value_reg <= '0;
        else
            value_reg <= value_next;
    end

    assign value = value_reg;

endmodule
`default_nettype wire

@@ sv/led_matrix_wrap_scroller.sv @@
`default_nettype none
// Channel   Direction  Handshake                Payload
// request   in         start & !busy            kind row col pixel direction time_step
// result    out        done (one cycle)         read_pixel in_range scrolled
// config    in         cfg_valid & cfg_ready    cfg_index cfg_data
//
// Each request passes an execute state, which updates the cell array (or picks the
// addressed column in each row), then an output state that shows the result on done.
// A new request is taken in the cycle its predecessor's result is shown.
// Fill and scroll move the whole active matrix together in the execute state, through the cells.
// Reset clears every cell, the elapsed-time accumulator, limit and flags; rows/cols reload 16/32.
// The receiver cannot stall; cfg_ready is always high.
module led_matrix_wrap_scroller
    import lmws_pkg::*;
#(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 32,
    parameter int PIXEL_BITS = 24
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [KIND_W-1:0]    kind,
    input  wire logic [ROW_W-1:0]     row,
    input  wire logic [COL_W-1:0]     col,
    input  wire logic [PIX_W-1:0]     pixel,
    input  wire logic [DIR_W-1:0]     direction,
    input  wire logic [STEP_W-1:0]    time_step,
    output logic                      done,
    output logic      [PIX_W-1:0]     read_pixel,
    output logic                      in_range,
    output logic                      scrolled,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int PW  = PIXEL_BITS;
    localparam int EW  = (PIXEL_BITS > PIX_W) ? PIXEL_BITS : PIX_W;
    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [ROWS_W-1:0]  rows_reg;
    logic [COLS_W-1:0]  cols_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [ELAPSE_W-1:0] elapsed_reg, elapsed_next;

    logic [KIND_W-1:0] kind_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [PW-1:0]     pix_reg;
    logic [DIR_W-1:0]  dir_reg;
    logic [STEP_W-1:0] step_reg;

    logic in_range_reg, scrolled_reg, rd_en_reg;
    logic [RIW-1:0] rd_row_reg;
    logic [PW-1:0]  pick_reg [MAX_ROWS];

    logic [RCW-1:0] nr;
    logic [CCW-1:0] nc;
    logic [RIW-1:0] nr_m1;
    logic [CIW-1:0] nc_m1;
    logic           pos_hit;
    logic           exec;
    logic           fire;
    logic [ELAPSE_W:0] sum;
    logic [ELAPSE_W-1:0] sum_sat;
    logic [EW-1:0]  pix_in_ext;
    logic [EW-1:0]  rd_ext;

    logic [PW-1:0] cell_q   [MAX_ROWS][MAX_COLS];
    logic [PW-1:0] row_last [MAX_ROWS];
    logic [PW-1:0] col_last [MAX_COLS];

    // Active size is clamped; the registers keep what was written.
    always_comb
    begin
        if (rows_reg == '0)
            nr = RCW'(1);
        else if (32'(rows_reg) > 32'(MAX_ROWS))
            nr = RCW'(MAX_ROWS);
        else
            nr = RCW'(rows_reg);
        if (cols_reg == '0)
            nc = CCW'(1);
        else if (32'(cols_reg) > 32'(MAX_COLS))
            nc = CCW'(MAX_COLS);
        else
            nc = CCW'(cols_reg);
    end

    assign nr_m1   = RIW'(nr - RCW'(1));
    assign nc_m1   = CIW'(nc - CCW'(1));
    assign pos_hit = (32'(row_reg) < 32'(nr)) && (32'(col_reg) < 32'(nc));
    assign exec    = (state_reg == ST_EXEC);

    assign sum     = {1'b0, elapsed_reg} + (ELAPSE_W + 1)'(step_reg);
    assign sum_sat = sum[ELAPSE_W] ? ELAPSE_MAX : sum[ELAPSE_W-1:0];
    assign fire    = exec && (kind_reg == KIND_TICK)
                     && (sum_sat > ELAPSE_W'(limit_reg));

    always_comb
    begin
        elapsed_next = elapsed_reg;
        if (exec && (kind_reg == KIND_TICK))
            elapsed_next = fire ? '0 : sum_sat;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_OUT;
            ST_OUT:  state_next = start ? ST_EXEC : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy      = (state_reg == ST_EXEC);
    assign cfg_ready = 1'b1;
    assign pix_in_ext = EW'(pixel);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rows_reg     <= ROWS_RESET;
            cols_reg     <= COLS_RESET;
            limit_reg    <= '0;
            elapsed_reg  <= '0;
            in_range_reg <= 1'b0;
            scrolled_reg <= 1'b0;
            rd_en_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_ROWS:  rows_reg  <= cfg_data[ROWS_W-1:0];
                    REG_COLS:  cols_reg  <= cfg_data[COLS_W-1:0];
                    REG_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                    default:   ;
                endcase
            end
            if (exec)
            begin
                in_range_reg <= ((kind_reg == KIND_WRITE) || (kind_reg == KIND_READ))
                                && pos_hit;
                rd_en_reg    <= (kind_reg == KIND_READ) && pos_hit;
                scrolled_reg <= fire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            kind_reg <= kind;
            row_reg  <= row;
            col_reg  <= col;
            pix_reg  <= pix_in_ext[PW-1:0];
            dir_reg  <= direction;
            step_reg <= time_step;
        end
        if (exec)
            rd_row_reg <= RIW'(row_reg);
    end

    // First read stage: each row picks the addressed column.
    for (genvar r = 0; r < MAX_ROWS; r++)
    begin : g_pick
        always_ff @(posedge clk)
        begin
            if (exec)
                pick_reg[r] <= cell_q[r][CIW'(col_reg)];
        end
        assign row_last[r] = cell_q[r][nc_m1];
    end

    for (genvar c = 0; c < MAX_COLS; c++)
    begin : g_col_last
        assign col_last[c] = cell_q[nr_m1][c];
    end

    assign rd_ext     = EW'(pick_reg[rd_row_reg]);
    assign done       = (state_reg == ST_OUT);
    assign read_pixel = rd_en_reg ? rd_ext[PIX_W-1:0] : '0;
    assign in_range   = in_range_reg;
    assign scrolled   = scrolled_reg;

    for (genvar r = 0; r < MAX_ROWS; r++)
    begin : g_row
        for (genvar c = 0; c < MAX_COLS; c++)
        begin : g_cell
            cell_sel_t     sel;
            logic          active;
            logic [PW-1:0] n_col, p_col, n_row, p_row, wrap;

            assign active = (32'(r) < 32'(nr)) && (32'(c) < 32'(nc));

            if (c + 1 < MAX_COLS) begin : g_nc
                assign n_col = cell_q[r][c+1];
            end else begin : g_nc_edge
                assign n_col = cell_q[r][c];
            end
            if (c > 0) begin : g_pc
                assign p_col = cell_q[r][c-1];
            end else begin : g_pc_edge
                assign p_col = cell_q[r][c];
            end
            if (r + 1 < MAX_ROWS) begin : g_nr
                assign n_row = cell_q[r+1][c];
            end else begin : g_nr_edge
                assign n_row = cell_q[r][c];
            end
            if (r > 0) begin : g_pr
                assign p_row = cell_q[r-1][c];
            end else begin : g_pr_edge
                assign p_row = cell_q[r][c];
            end

            always_comb
            begin
                unique case (dir_reg)
                    DIR_LEFT:  wrap = cell_q[r][0];
                    DIR_RIGHT: wrap = row_last[r];
                    DIR_UP:    wrap = cell_q[0][c];
                    DIR_DOWN:  wrap = col_last[c];
                    default:   wrap = cell_q[r][c];
                endcase
            end

            always_comb
            begin
                sel = SEL_HOLD;
                if (exec && active)
                begin
                    unique case (kind_reg)
                        KIND_WRITE:
                            if ((32'(row_reg) == 32'(r)) && (32'(col_reg) == 32'(c)))
                                sel = SEL_LOAD;
                        KIND_FILL:
                            sel = SEL_LOAD;
                        KIND_TICK:
                            if (fire)
                            begin
                                unique case (dir_reg)
                                    DIR_LEFT:
                                        if (32'(nc) >= 32'd2)
                                            sel = (32'(c) == 32'(nc_m1)) ? SEL_WRAP
                                                                         : SEL_NEXT_COL;
                                    DIR_RIGHT:
                                        if (32'(nc) >= 32'd2)
                                            sel = (c == 0) ? SEL_WRAP : SEL_PREV_COL;
                                    DIR_UP:
                                        if (32'(nr) >= 32'd2)
                                            sel = (32'(r) == 32'(nr_m1)) ? SEL_WRAP
                                                                         : SEL_NEXT_ROW;
                                    DIR_DOWN:
                                        if (32'(nr) >= 32'd2)
                                            sel = (r == 0) ? SEL_WRAP : SEL_PREV_ROW;
                                    default: sel = SEL_HOLD;
                                endcase
                            end
                        default: sel = SEL_HOLD;
                    endcase
                end
            end

            lmws_cell #(
                .PW(PW)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .sel       (sel),
                .load_data (pix_reg),
                .next_col  (n_col),
                .prev_col  (p_col),
                .next_row  (n_row),
                .prev_row  (p_row),
                .wrap_data (wrap),
                .value     (cell_q[r][c])
            );
        end
    end

`ifndef SYNTHESIS
    a_exec_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("execute cycle not followed by a result");
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(scrolled && in_range))
        else $error("scroll and position flag both set");
    a_scroll_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (done && scrolled) |-> (elapsed_reg == '0))
        else $error("accumulator not cleared after a scroll step");
    a_read_only_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (read_pixel != '0)) |-> in_range)
        else $error("pixel returned for a position outside the matrix");
`endif

endmodule
`default_nettype wire
